// File: rtl/ebrf_pkg.sv
// ----------------------------------------------------------------------------
// ebrf_pkg
// Shared types and constants of the escaped byte receive fifo.
// ----------------------------------------------------------------------------
`default_nettype none

package ebrf_pkg;

	// field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned MARK_W    = 9;
	localparam int unsigned REG_IDX_W = 1;

	// default geometry
	localparam int unsigned DEF_FIFO_DEPTH  = 256;
	localparam int unsigned DEF_PURGE_BLOCK = 8;

	// special line bytes
	localparam logic [BYTE_W-1:0] ESC_CHAR  = 8'h5C;
	localparam logic [BYTE_W-1:0] FILL_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] FILL_ONES = 8'hFF;

	// operation codes
	localparam logic OP_LINE = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_HIGH_MARK = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_LOW_MARK  = 1'b1;

	// one result beat
	typedef struct packed {
		logic              stored;
		logic              purged;
		logic              high_event;
		logic              low_event;
		logic              read_valid;
		logic [BYTE_W-1:0] read_byte;
		logic [MARK_W-1:0] fill_level;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/ebrf_if.sv
// ----------------------------------------------------------------------------
// ebrf_req_if / ebrf_rsp_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ebrf_req_if;
	import ebrf_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [BYTE_W-1:0] line_byte;

	modport source (output valid, output operation, output line_byte, input ready);
	modport sink (input valid, input operation, input line_byte, output ready);
endinterface

interface ebrf_rsp_if;
	import ebrf_pkg::*;

	logic              valid;
	logic              ready;
	logic              stored;
	logic              purged;
	logic              high_event;
	logic              low_event;
	logic              read_valid;
	logic [BYTE_W-1:0] read_byte;
	logic [MARK_W-1:0] fill_level;

	modport source (
		output valid, output stored, output purged, output high_event,
		output low_event, output read_valid, output read_byte,
		output fill_level, input ready
	);
	modport sink (
		input valid, input stored, input purged, input high_event,
		input low_event, input read_valid, input read_byte,
		input fill_level, output ready
	);
endinterface

`default_nettype wire

// File: rtl/escaped_byte_receive_fifo.sv
// A taken request beat passes the stage 1 register and the result queue before its result beat is offered.
// Throughput: one request per cycle while ready is high; pointer, count and flag
// updates finish in the accept cycle, and the byte ram read/write happens on that same edge.
// Ready drops only while three result beats are pending on the result side.
// Reset clears pointers, count, escape and watermark flags and both marks;
// the byte ram is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// escaped_byte_receive_fifo
// Line bytes are unescaped and filler-stripped into a ring buffer held in a
// ram; host pops return the oldest byte. Watermark events with hysteresis.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_byte_receive_fifo #(
	parameter int unsigned FIFO_DEPTH  = ebrf_pkg::DEF_FIFO_DEPTH,
	parameter int unsigned PURGE_BLOCK = ebrf_pkg::DEF_PURGE_BLOCK
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ebrf_pkg::REG_IDX_W-1:0] cfg_index,
	input  wire logic [ebrf_pkg::MARK_W-1:0]    cfg_data,
	ebrf_req_if.sink                            req,
	ebrf_rsp_if.source                          rsp
);
	import ebrf_pkg::*;

	localparam int unsigned AW   = $clog2(FIFO_DEPTH);
	localparam int unsigned CW   = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned MW   = (CW + 1 > MARK_W) ? CW + 1 : MARK_W;
	localparam int unsigned DROP = (PURGE_BLOCK < FIFO_DEPTH) ? PURGE_BLOCK : FIFO_DEPTH;
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(FIFO_DEPTH);
	localparam logic [AW:0]   DROP_A  = (AW + 1)'(DROP);
	localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);

	// ring pointer add, sum stays below twice the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW:0] sum);
		return (sum >= DEPTH_A) ? AW'(sum - DEPTH_A) : AW'(sum);
	endfunction

	logic [MARK_W-1:0] high_mark_q;
	logic [MARK_W-1:0] low_mark_q;
	logic [AW-1:0]     oldest_q;
	logic [CW-1:0]     count_q;
	logic              esc_q;
	logic              hs_q;

	logic [AW-1:0]     oldest_n;
	logic [CW-1:0]     count_n;
	logic              esc_n;
	logic              hs_n;
	logic              hs_mid;
	logic              take;
	logic [MW-1:0]     next_m;
	logic [AW-1:0]     base_o;
	logic [AW:0]       base_c;
	logic [AW:0]       count_a;
	logic [CW+MARK_W-1:0] fill_ext;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	logic              accept;
	result_t           res;
	logic              valid_s1;
	result_t           res_s1;
	result_t           push_data;
	logic [1:0]        q_level;
	logic [2:0]        occupancy;
	logic              q_valid;
	result_t           q_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_mark_q <= '0;
			low_mark_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIGH_MARK: high_mark_q <= cfg_data;
				REG_LOW_MARK:  low_mark_q  <= cfg_data;
				default:       high_mark_q <= high_mark_q;
			endcase
		end
	end

	// accept while fewer than three results are pending
	assign occupancy = {2'b00, valid_s1} + {1'b0, q_level};
	assign req.ready = (occupancy <= 3'd2);
	assign accept    = req.valid && req.ready;

	assign count_a = (AW + 1)'(count_q);

	// step logic: unescape, watermarks, purge, append or pop
	always_comb begin
		oldest_n  = oldest_q;
		count_n   = count_q;
		esc_n     = esc_q;
		hs_n      = hs_q;
		hs_mid    = hs_q;
		take      = 1'b0;
		next_m    = MW'(count_q) + MW'(1);
		base_o    = oldest_q;
		base_c    = count_a;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = oldest_q;
		res       = '0;
		if (req.operation == OP_POP) begin
			if (count_q != '0) begin
				ram_re         = 1'b1;
				res.read_valid = 1'b1;
				oldest_n       = wrap_add({1'b0, oldest_q} + (AW + 1)'(1));
				count_n        = count_q - CW'(1);
			end
		end else begin
			if (!esc_q && req.line_byte == ESC_CHAR) begin
				esc_n = 1'b1;
			end else if (esc_q) begin
				esc_n = 1'b0;
				take  = 1'b1;
			end else if (req.line_byte != FILL_ZERO && req.line_byte != FILL_ONES) begin
				take = 1'b1;
			end
			if (take) begin
				// watermarks against the fill before this byte plus one, taken before any purge
				if (high_mark_q != '0 && next_m >= MW'(high_mark_q) && !hs_q) begin
					res.high_event = 1'b1;
					hs_mid         = 1'b1;
				end
				hs_n = hs_mid;
				if (low_mark_q != '0 && next_m <= MW'(low_mark_q) && hs_mid) begin
					res.low_event = 1'b1;
					hs_n          = 1'b0;
				end
				// full ring drops the oldest block first
				if (count_q == DEPTH_C) begin
					base_o     = wrap_add({1'b0, oldest_q} + DROP_A);
					base_c     = DEPTH_A - DROP_A;
					res.purged = 1'b1;
				end
				ram_we     = 1'b1;
				ram_waddr  = wrap_add({1'b0, base_o} + base_c);
				oldest_n   = base_o;
				count_n    = CW'(base_c + (AW + 1)'(1));
				res.stored = 1'b1;
			end
		end
		fill_ext       = {{MARK_W{1'b0}}, count_n};
		res.fill_level = fill_ext[MARK_W-1:0];
		if (!accept) begin
			ram_we = 1'b0;
			ram_re = 1'b0;
		end
	end

	// pointer and flag state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q  <= '0;
			esc_q    <= 1'b0;
			hs_q     <= 1'b0;
		end else if (accept) begin
			oldest_q <= oldest_n;
			count_q  <= count_n;
			esc_q    <= esc_n;
			hs_q     <= hs_n;
		end
	end

	// byte ring; a pop never reads the entry written on the same edge
	ebrf_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.line_byte),
		.re    (ram_re),
		.raddr (oldest_q),
		.rdata (ram_rdata)
	);

	// stage 1 waits for the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// merge the popped byte into the result beat
	always_comb begin
		push_data           = res_s1;
		push_data.read_byte = res_s1.read_valid ? ram_rdata : '0;
	end

	ebrf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (push_data),
		.pop_ready (rsp.ready),
		.out_valid (q_valid),
		.out_data  (q_data),
		.level     (q_level)
	);

	// result channel
	assign rsp.valid      = q_valid;
	assign rsp.stored     = q_data.stored;
	assign rsp.purged     = q_data.purged;
	assign rsp.high_event = q_data.high_event;
	assign rsp.low_event  = q_data.low_event;
	assign rsp.read_valid = q_data.read_valid;
	assign rsp.read_byte  = q_data.read_byte;
	assign rsp.fill_level = q_data.fill_level;

endmodule

`default_nettype wire

// File: rtl/ebrf_ram.sv
// ----------------------------------------------------------------------------
// ebrf_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ebrf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/ebrf_outq.sv
// ----------------------------------------------------------------------------
// ebrf_outq
// Three-entry result queue that decouples the result side from the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ebrf_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ebrf_pkg::result_t push_data,
	input  wire logic              pop_ready,
	output logic                   out_valid,
	output ebrf_pkg::result_t      out_data,
	output logic [1:0]             level
);
	import ebrf_pkg::*;

	localparam logic [1:0] LAST = 2'd2;

	result_t    entry_q [3];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = entry_q[rd_q];
	assign level     = cnt_q;
	assign pop       = out_valid && pop_ready;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? 2'd0 : wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? 2'd0 : rd_q + 2'd1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/ebrf_chk.sv
// ----------------------------------------------------------------------------
// ebrf_chk
// Port-level checks of the escaped byte receive fifo, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ebrf_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic                           stored,
	input wire logic                           purged,
	input wire logic                           high_event,
	input wire logic                           low_event,
	input wire logic                           read_valid,
	input wire logic [ebrf_pkg::BYTE_W-1:0]    read_byte
);
	import ebrf_pkg::*;

	// a pending result beat stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat withdrawn before it was taken");

	// a pop beat carries no line-side flags
	a_pop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_valid |-> !stored && !purged && !high_event && !low_event)
		else $error("pop beat reports line-side activity");

	// a purge always makes room for the byte that caused it
	a_purge_store: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && purged |-> stored)
		else $error("purge without store");

	// no byte is shown when nothing was popped
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !read_valid |-> read_byte == '0)
		else $error("read byte nonzero without a pop");

endmodule

bind escaped_byte_receive_fifo ebrf_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.stored     (rsp.stored),
	.purged     (rsp.purged),
	.high_event (rsp.high_event),
	.low_event  (rsp.low_event),
	.read_valid (rsp.read_valid),
	.read_byte  (rsp.read_byte)
);

`default_nettype wire
